FILE: rtl/core/sorted_key_value_table_defines.svh
// ----------------------------------------------------------------------------
// sorted_key_value_table_defines
// Assertion macros used by the port-level checker of the sorted key/value table.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_VALUE_TABLE_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_DEFINES_SVH

// Property checked on every rising edge while the block is out of reset.
`define SKVT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define SKVT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Types, sizes and codes of the sorted key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

  localparam int TABLE_SLOTS = 256;
  localparam int IDX_W       = $clog2(TABLE_SLOTS);
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int ENT_W       = KEY_W + VAL_W;
  localparam int OP_W        = 2;
  localparam int STS_W       = 2;
  localparam int OUT_W       = 8;

  localparam logic [KEY_W-1:0] KEY_RESERVED = {KEY_W{1'b1}};

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [ENT_W-1:0] entry_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_FIND   = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RESERVED = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_MOVE,
    S_DRAIN,
    S_PUT,
    S_RESP
  } state_t;

endpackage

FILE: rtl/core/sorted_key_value_table.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Key/value table kept in ascending key order in a single-port-write memory.
// A shared key comparator serves the binary search of add, find and delete;
// add and delete then move the entries above the target by one slot.
//
//   channel   handshake            beat contents
//   in        in_valid/in_ready    in_op, in_key, in_value
//   out       out_valid/out_ready  out_status, out_found_value, out_position,
//                                  out_entry_count
//
// One operation is in flight at a time; in_ready is high only when idle.
// A search probe reads the memory, then compares the key; at most
// log2(TABLE_SLOTS) probes are made, and an add or a miss closes the search
// in S_PROBE once the range is empty. Each entry moved is read, then written
// into its new slot, and a drain state finishes the last write. Rejected adds
// and the unused op code go straight to the result.
// Reset empties the table at once; the result stays put while out_ready is low.
// ----------------------------------------------------------------------------
module sorted_key_value_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [skvt_pkg::OP_W-1:0]     in_op,
  input  logic [skvt_pkg::KEY_W-1:0]    in_key,
  input  logic [skvt_pkg::VAL_W-1:0]    in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [skvt_pkg::STS_W-1:0]    out_status,
  output logic [skvt_pkg::VAL_W-1:0]    out_found_value,
  output logic [skvt_pkg::OUT_W-1:0]    out_position,
  output logic [skvt_pkg::OUT_W-1:0]    out_entry_count
);

  localparam int IW = skvt_pkg::IDX_W;

  skvt_pkg::state_t state_r, state_nxt;

  logic [skvt_pkg::OP_W-1:0]  op_r,   op_nxt;
  logic [skvt_pkg::KEY_W-1:0] key_r,  key_nxt;
  logic [skvt_pkg::VAL_W-1:0] val_r,  val_nxt;
  logic [skvt_pkg::VAL_W-1:0] fval_r, fval_nxt;
  skvt_pkg::status_t          sts_r,  sts_nxt;
  skvt_pkg::idx_t             lo_r,   lo_nxt;
  skvt_pkg::idx_t             he_r,   he_nxt;
  skvt_pkg::idx_t             mid_r,  mid_nxt;
  skvt_pkg::idx_t             ptr_r,  ptr_nxt;
  skvt_pkg::idx_t             pos_r,  pos_nxt;
  skvt_pkg::idx_t             count_r, count_nxt;
  logic                       pend_r, pend_nxt;
  skvt_pkg::idx_t             pend_addr_r, pend_addr_nxt;

  // Table memory.
  skvt_pkg::entry_t ent_mem [skvt_pkg::TABLE_SLOTS];
  skvt_pkg::entry_t rdata_r;
  skvt_pkg::idx_t   rd_addr;
  logic             we;
  skvt_pkg::idx_t   wa;
  skvt_pkg::entry_t wd;

  logic [IW:0]                mid_sum;
  skvt_pkg::idx_t             mid;
  logic [skvt_pkg::KEY_W-1:0] rd_key;
  logic [skvt_pkg::VAL_W-1:0] rd_val;
  logic                       k_lt;
  logic                       k_gt;
  logic                       is_add;
  logic                       is_del;
  logic                       in_rsvd;
  logic                       in_full;
  logic                       move_last;

  always_ff @(posedge clk) begin
    if (we) begin
      ent_mem[wa] <= wd;
    end
    rdata_r <= ent_mem[rd_addr];
  end

  // Shared search unit: midpoint of [lo, he) rounded down, and key compare.
  assign mid_sum = {1'b0, lo_r} + {1'b0, he_r} - (IW+1)'(1);
  assign mid     = mid_sum[IW:1];
  assign rd_key  = rdata_r[skvt_pkg::ENT_W-1 -: skvt_pkg::KEY_W];
  assign rd_val  = rdata_r[skvt_pkg::VAL_W-1:0];
  assign k_lt    = key_r < rd_key;
  assign k_gt    = key_r > rd_key;
  assign is_add  = (op_r == skvt_pkg::OP_ADD);
  assign is_del  = (op_r == skvt_pkg::OP_DELETE);
  assign in_rsvd = (in_key == skvt_pkg::KEY_RESERVED);
  assign in_full = ({1'b0, count_r} + (IW+1)'(1)) >= (IW+1)'(skvt_pkg::TABLE_SLOTS);

  // Inserts walk down toward the insert point, deletes walk up to the end.
  assign move_last = is_add ? ((ptr_r - IW'(1)) == pos_r)
                            : (({1'b0, ptr_r} + (IW+1)'(1)) >= {1'b0, count_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      skvt_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_op) inside
            skvt_pkg::OP_ADD: begin
              state_nxt = (in_rsvd || in_full) ? skvt_pkg::S_RESP : skvt_pkg::S_PROBE;
            end
            skvt_pkg::OP_FIND, skvt_pkg::OP_DELETE: begin
              state_nxt = skvt_pkg::S_PROBE;
            end
            default: begin
              state_nxt = skvt_pkg::S_RESP;
            end
          endcase
        end
      end
      skvt_pkg::S_PROBE: begin
        if (lo_r < he_r) begin
          state_nxt = skvt_pkg::S_CMP;
        end else if (is_add) begin
          state_nxt = (lo_r == count_r) ? skvt_pkg::S_PUT : skvt_pkg::S_MOVE;
        end else begin
          state_nxt = skvt_pkg::S_RESP;
        end
      end
      skvt_pkg::S_CMP: begin
        if (k_lt || k_gt || is_add) begin
          state_nxt = skvt_pkg::S_PROBE;
        end else if (is_del && (({1'b0, mid_r} + (IW+1)'(1)) < {1'b0, count_r})) begin
          state_nxt = skvt_pkg::S_MOVE;
        end else begin
          state_nxt = skvt_pkg::S_RESP;
        end
      end
      skvt_pkg::S_MOVE: begin
        if (move_last) begin
          state_nxt = skvt_pkg::S_DRAIN;
        end
      end
      skvt_pkg::S_DRAIN: begin
        state_nxt = is_add ? skvt_pkg::S_PUT : skvt_pkg::S_RESP;
      end
      skvt_pkg::S_PUT: begin
        state_nxt = skvt_pkg::S_RESP;
      end
      skvt_pkg::S_RESP: begin
        if (out_ready) begin
          state_nxt = skvt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = skvt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    op_nxt        = op_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    fval_nxt      = fval_r;
    sts_nxt       = sts_r;
    lo_nxt        = lo_r;
    he_nxt        = he_r;
    mid_nxt       = mid_r;
    ptr_nxt       = ptr_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    rd_addr       = mid;
    we            = pend_r;
    wa            = pend_addr_r;
    wd            = rdata_r;

    unique case (state_r)
      skvt_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_op;
          key_nxt  = in_key;
          val_nxt  = in_value;
          fval_nxt = '0;
          pos_nxt  = '0;
          lo_nxt   = '0;
          he_nxt   = count_r;
          sts_nxt  = skvt_pkg::ST_OK;
          if (in_op == skvt_pkg::OP_ADD) begin
            if (in_rsvd) begin
              sts_nxt = skvt_pkg::ST_RESERVED;
            end else if (in_full) begin
              sts_nxt = skvt_pkg::ST_FULL;
            end
          end
        end
      end
      skvt_pkg::S_PROBE: begin
        if (lo_r < he_r) begin
          mid_nxt = mid;
        end else if (is_add) begin
          pos_nxt = lo_r;
          ptr_nxt = count_r;
        end else begin
          sts_nxt = skvt_pkg::ST_MISSING;
        end
      end
      skvt_pkg::S_CMP: begin
        // An add searches for the first key above its own, so equal goes up.
        if (k_lt) begin
          he_nxt = mid_r;
        end else if (k_gt || is_add) begin
          lo_nxt = mid_r + IW'(1);
        end else begin
          pos_nxt  = mid_r;
          fval_nxt = rd_val;
          if (is_del) begin
            count_nxt = count_r - IW'(1);
            ptr_nxt   = mid_r;
          end
        end
      end
      skvt_pkg::S_MOVE: begin
        // Read the neighbor now; it is written into the current ptr_r slot on the next cycle.
        rd_addr       = is_add ? (ptr_r - IW'(1)) : (ptr_r + IW'(1));
        ptr_nxt       = rd_addr;
        pend_nxt      = 1'b1;
        pend_addr_nxt = ptr_r;
      end
      skvt_pkg::S_DRAIN: begin
        pend_nxt = 1'b0;
      end
      skvt_pkg::S_PUT: begin
        we        = 1'b1;
        wa        = pos_r;
        wd        = {key_r, val_r};
        count_nxt = count_r + IW'(1);
      end
      skvt_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    in_ready  = (state_r == skvt_pkg::S_IDLE);
    out_valid = (state_r == skvt_pkg::S_RESP);
  end

  assign out_status      = sts_r;
  assign out_found_value = fval_r;
  assign out_position    = skvt_pkg::OUT_W'(pos_r);
  assign out_entry_count = skvt_pkg::OUT_W'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skvt_pkg::S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    fval_r      <= fval_nxt;
    sts_r       <= sts_nxt;
    lo_r        <= lo_nxt;
    he_r        <= he_nxt;
    mid_r       <= mid_nxt;
    ptr_r       <= ptr_nxt;
    pos_r       <= pos_nxt;
    pend_addr_r <= pend_addr_nxt;
  end

endmodule

FILE: rtl/core/skvt_checker.sv
// ----------------------------------------------------------------------------
// skvt_checker
// Port-level checks of the sorted key/value table, bound to its top level.
// ----------------------------------------------------------------------------
`include "sorted_key_value_table_defines.svh"

module skvt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [skvt_pkg::OP_W-1:0]     in_op,
  input logic [skvt_pkg::KEY_W-1:0]    in_key,
  input logic [skvt_pkg::VAL_W-1:0]    in_value,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [skvt_pkg::STS_W-1:0]    out_status,
  input logic [skvt_pkg::VAL_W-1:0]    out_found_value,
  input logic [skvt_pkg::OUT_W-1:0]    out_position,
  input logic [skvt_pkg::OUT_W-1:0]    out_entry_count
);

  // A waiting input beat keeps its contents until it is taken.
  `SKVT_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_op) && $stable(in_key) && $stable(in_value), "input beat changed while waiting")

  // A stalled result beat keeps its contents.
  `SKVT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_found_value) && $stable(out_position) && $stable(out_entry_count), "result beat changed while stalled")

  // Only one operation is in flight: no new beat is taken while a result waits.
  `SKVT_ASSERT(a_one_in_flight, in_valid && in_ready |-> !out_valid, "input taken while a result is pending")

  // Failed operations report neither a value nor a position.
  `SKVT_ASSERT(a_fail_zero, out_valid && (out_status != skvt_pkg::ST_OK) |-> (out_found_value == '0) && (out_position == '0), "failed operation reports value or position")

  // Reset leaves the block idle with no result pending.
  `SKVT_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && in_ready, "block not idle after reset")

endmodule

bind sorted_key_value_table skvt_checker u_skvt_checker (.*);

FILE: dv/sorted_key_value_table_checker.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table_checker
// Watches both channels of the sorted key/value table. It keeps its own copy
// of the ordered table, works out the answer of every accepted operation and
// compares each result beat, field by field, with the oldest answer waiting.
// ----------------------------------------------------------------------------
module sorted_key_value_table_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [skvt_pkg::OP_W-1:0]     in_op,
  input  logic [skvt_pkg::KEY_W-1:0]    in_key,
  input  logic [skvt_pkg::VAL_W-1:0]    in_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [skvt_pkg::STS_W-1:0]    out_status,
  input  logic [skvt_pkg::VAL_W-1:0]    out_found_value,
  input  logic [skvt_pkg::OUT_W-1:0]    out_position,
  input  logic [skvt_pkg::OUT_W-1:0]    out_entry_count,
  output int                            errors,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import skvt_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] found_value;
    logic [OUT_W-1:0] position;
    logic [OUT_W-1:0] entry_count;
  } table_answer_t;

  logic [KEY_W-1:0] slot_key [TABLE_SLOTS];
  logic [VAL_W-1:0] slot_val [TABLE_SLOTS];
  int               live;
  table_answer_t    answer_q [$];

  // Binary search with inclusive bounds and the midpoint rounded down; the
  // first probe that matches wins, which is not always the first equal key.
  function automatic bit search_key(input logic [KEY_W-1:0] k, output int at);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = live - 1;
    at = 0;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (k < slot_key[mid]) begin
        hi = mid - 1;
      end else if (k > slot_key[mid]) begin
        lo = mid + 1;
      end else begin
        at = mid;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic table_answer_t apply_table_op(input logic [OP_W-1:0] op,
                                                   input logic [KEY_W-1:0] k,
                                                   input logic [VAL_W-1:0] v);
    table_answer_t r;
    int at;
    int i;
    r.status      = ST_OK;
    r.found_value = '0;
    r.position    = '0;
    case (op)
      OP_ADD: begin
        if (k == KEY_RESERVED) begin
          r.status = ST_RESERVED;
        end else if (live + 1 >= TABLE_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          // Insert after every entry with an equal key.
          at = live;
          for (i = live - 1; i >= 0; i--) begin
            if (slot_key[i] > k) at = i;
          end
          for (i = live; i > at; i--) begin
            slot_key[i] = slot_key[i-1];
            slot_val[i] = slot_val[i-1];
          end
          slot_key[at] = k;
          slot_val[at] = v;
          live++;
          r.position = OUT_W'(at);
        end
      end
      OP_FIND, OP_DELETE: begin
        if (search_key(k, at)) begin
          r.position    = OUT_W'(at);
          r.found_value = slot_val[at];
          if (op == OP_DELETE) begin
            for (i = at; i + 1 < live; i++) begin
              slot_key[i] = slot_key[i+1];
              slot_val[i] = slot_val[i+1];
            end
            live--;
          end
        end else begin
          r.status = ST_MISSING;
        end
      end
      default: ;
    endcase
    r.entry_count = OUT_W'(live);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    table_answer_t due;
    if (!rst_n) begin
      live = 0;
      answer_q.delete();
    end else begin
      // The result leaving at this edge belongs to an earlier operation, so
      // it is checked before a beat accepted at the same edge is predicted.
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: result beat with no operation outstanding", $time);
          errors++;
        end else begin
          due = answer_q.pop_front();
          if (out_status !== due.status) begin
            $display("%0t: status expected %0d got %0d", $time, due.status, out_status);
            errors++;
          end
          if (out_found_value !== due.found_value) begin
            $display("%0t: found_value expected %h got %h", $time, due.found_value,
                     out_found_value);
            errors++;
          end
          if (out_position !== due.position) begin
            $display("%0t: position expected %0d got %0d", $time, due.position,
                     out_position);
            errors++;
          end
          if (out_entry_count !== due.entry_count) begin
            $display("%0t: entry_count expected %0d got %0d", $time, due.entry_count,
                     out_entry_count);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        answer_q.push_back(apply_table_op(in_op, in_key, in_value));
      end
    end
    outstanding = answer_q.size();
  end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives add, find and delete beats into the sorted key/value table: a
// directed opening on the table's edge cases, a burst of adds that fills the
// table, then random mixes that lean toward growth or shrinkage. Both sides
// idle at random and the receiver once stalls for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import skvt_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int DRAIN_CYCLES  = 300;
  localparam int FILL_ITEMS    = 270;
  localparam int SEGMENT_ITEMS = 40;
  localparam int RECENT_KEYS   = 16;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_op     = OP_ADD;
  logic [KEY_W-1:0]     in_key    = '0;
  logic [VAL_W-1:0]     in_value  = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STS_W-1:0]     out_status;
  logic [VAL_W-1:0]     out_found_value;
  logic [OUT_W-1:0]     out_position;
  logic [OUT_W-1:0]     out_entry_count;
  int                   errors;
  int                   outstanding;

  int                   tx_idle_pct = 0;
  int                   rx_idle_pct = 0;
  int                   hold_req    = 0;
  int                   hold_seen   = 0;
  int                   hold_left   = 0;
  int                   cycle_count = 0;
  logic [KEY_W-1:0]     recent_key [RECENT_KEYS];
  int                   recent_wr   = 0;

  sorted_key_value_table dut (.*);

  sorted_key_value_table_checker checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    foreach (recent_key[i]) recent_key[i] = '0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                           input logic [VAL_W-1:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_key   <= k;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 35) return KEY_W'($urandom_range(15));
    if (r < 65) return recent_key[$urandom_range(RECENT_KEYS - 1)];
    if (r < 75) begin
      case ($urandom_range(4))
        0:       return '0;
        1:       return KEY_RESERVED - 1;
        2:       return 32'h8000_0000;
        3:       return 32'h7FFF_FFFF;
        default: return KEY_RESERVED;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return $urandom;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int add_pct);
    if ($urandom_range(99) < 3) return OP_UNUSED;
    if ($urandom_range(99) < add_pct) return OP_ADD;
    return $urandom_range(1) ? OP_FIND : OP_DELETE;
  endfunction

  task automatic run_items(input int n, input int add_pct);
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      op = pick_op(add_pct);
      k  = pick_key();
      // Remember added keys so that later finds and deletes can hit them.
      if (op == OP_ADD && k != KEY_RESERVED) begin
        recent_key[recent_wr % RECENT_KEYS] = k;
        recent_wr++;
      end
      send_beat(op, k, pick_value());
    end
  endtask

  // Each segment leans toward growth, balance or shrinkage.
  task automatic run_segments(input int segments);
    int add_pct;
    for (int s = 0; s < segments; s++) begin
      case ($urandom_range(2))
        0:       add_pct = 80;
        1:       add_pct = 45;
        default: add_pct = 15;
      endcase
      run_items(SEGMENT_ITEMS, add_pct);
    end
  endtask

  task automatic set_idle(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_idle(9, 76);

    // Empty table, reserved key, duplicates, both ends and the middle.
    send_beat(OP_FIND,   32'd0,         32'd0);
    send_beat(OP_DELETE, 32'd5,         32'd0);
    send_beat(OP_ADD,    KEY_RESERVED,  32'h1234_5678);
    send_beat(OP_ADD,    32'd0,         32'd0);
    send_beat(OP_ADD,    KEY_RESERVED - 1, '1);
    send_beat(OP_ADD,    32'd10,        32'hAAAA_0001);
    send_beat(OP_ADD,    32'd10,        32'hAAAA_0002);
    send_beat(OP_ADD,    32'd10,        32'hAAAA_0003);
    send_beat(OP_FIND,   32'd10,        32'd0);
    send_beat(OP_DELETE, 32'd10,        '1);
    send_beat(OP_FIND,   KEY_RESERVED,  32'd0);
    send_beat(OP_DELETE, KEY_RESERVED,  32'd0);
    send_beat(OP_UNUSED, 32'd10,        32'h5555_5555);
    send_beat(OP_FIND,   32'd0,         32'd0);
    send_beat(OP_FIND,   KEY_RESERVED - 1, 32'd0);
    send_beat(OP_DELETE, 32'd0,         32'd0);
    send_beat(OP_DELETE, KEY_RESERVED - 1, 32'd0);
    send_beat(OP_ADD,    32'd5,         32'h0000_0005);
    send_beat(OP_ADD,    32'd20,        32'h0000_0014);
    send_beat(OP_FIND,   32'd7,         32'd0);
    send_beat(OP_DELETE, 32'd7,         32'd0);

    // Fill the table past its limit so that adds are turned away.
    run_items(FILL_ITEMS, 100);
    run_segments(4);

    set_idle(76, 9);
    run_segments(10);

    // No idling; the receiver first stalls long enough to back up the input.
    set_idle(0, 0);
    hold_req <= hold_req + 1;
    run_segments(10);

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sorted_key_value_table.f
+incdir+rtl/core
rtl/core/skvt_pkg.sv
rtl/core/sorted_key_value_table.sv
rtl/core/skvt_checker.sv
dv/sorted_key_value_table_checker.sv
dv/tb.sv
